// File: hw/rtl/ftss_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-timestep step scheduler package
// Widths, payload structs, configuration indexes and the sequencer's
// microcode table shared by the scheduler RTL.
// ----------------------------------------------------------------------------
package ftss_pkg;

  // Field widths.
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned SIM_W      = 40;
  localparam int unsigned STEPS_W    = 7;
  localparam int unsigned FDT_W      = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TICK_ACC_W = 40;
  localparam int unsigned TIME_ACC_W = 48;
  localparam int unsigned PROD_W     = FRAME_W + SCALE_W;

  // Lock-step tick cap and the width that holds a tick count up to it.
  localparam int unsigned MAX_LOCK_TICKS = 32;
  localparam int unsigned TICK_W         = $clog2(MAX_LOCK_TICKS + 1);

  // Hard cap on steps drained per frame in free-running mode.
  localparam int unsigned STEP_CAP = 64;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_DT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = CFG_IDX_W'(1);

  localparam logic [FDT_W-1:0]   FIXED_DT_RESET  = FDT_W'(546);
  localparam logic [STEPS_W-1:0] MAX_STEPS_RESET = STEPS_W'(8);

  // Input transaction.
  typedef struct packed {
    logic [FRAME_W-1:0]        frame_seconds;
    logic signed [SCALE_W-1:0] speed_scale;
    logic                      scene_mode;
    logic                      scene_physics_on;
    logic                      fly_mode;
    logic                      nudge_mode;
    logic                      step_request;
    logic                      lock_step;
    logic                      models_present;
  } ftss_in_t;

  // Result transaction.
  typedef struct packed {
    logic                      update_logic;
    logic [FRAME_W-1:0]        camera_dt;
    logic signed [SIM_W-1:0]   sim_dt;
    logic [STEPS_W-1:0]        steps_run;
  } ftss_out_t;

  // Sequencer program counter.
  localparam int unsigned PC_W = 4;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_FSIM,
    OP_FACC,
    OP_DRAIN,
    OP_FCAP,
    OP_LADD,
    OP_LTAKE,
    OP_LSIM,
    OP_EMIT
  } ftss_op_e;

  // Jump conditions; a true condition loads the target, else pc + 1.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_BLOCKED,
    C_LOCK,
    C_NO_STEP,
    C_CAN_DRAIN,
    C_OUT_BUSY
  } ftss_cond_e;

  typedef struct packed {
    ftss_op_e         op;
    ftss_cond_e       cond;
    logic [PC_W-1:0]  target;
  } ftss_uword_t;

  // Program addresses.
  localparam logic [PC_W-1:0] A_WAIT   = PC_W'(0);
  localparam logic [PC_W-1:0] A_CHECK  = PC_W'(1);
  localparam logic [PC_W-1:0] A_MODE   = PC_W'(2);
  localparam logic [PC_W-1:0] A_FMUL   = PC_W'(3);
  localparam logic [PC_W-1:0] A_FSIM   = PC_W'(4);
  localparam logic [PC_W-1:0] A_FACC   = PC_W'(5);
  localparam logic [PC_W-1:0] A_DRAIN  = PC_W'(6);
  localparam logic [PC_W-1:0] A_FCAP   = PC_W'(7);
  localparam logic [PC_W-1:0] A_LADD   = PC_W'(8);
  localparam logic [PC_W-1:0] A_LTAKE  = PC_W'(9);
  localparam logic [PC_W-1:0] A_LSIM   = PC_W'(10);
  localparam logic [PC_W-1:0] A_EMIT   = PC_W'(11);
  localparam logic [PC_W-1:0] A_DONE   = PC_W'(12);

  // Microcode table.
  function automatic ftss_uword_t ftss_ucode(input logic [PC_W-1:0] addr);
    ftss_uword_t w;
    unique case (addr)
      A_WAIT:  w = '{op: OP_LOAD,  cond: C_NO_ITEM,   target: A_WAIT};
      A_CHECK: w = '{op: OP_NOP,   cond: C_BLOCKED,   target: A_EMIT};
      A_MODE:  w = '{op: OP_NOP,   cond: C_LOCK,      target: A_LADD};
      A_FMUL:  w = '{op: OP_MUL,   cond: C_NEVER,     target: A_WAIT};
      A_FSIM:  w = '{op: OP_FSIM,  cond: C_NO_STEP,   target: A_EMIT};
      A_FACC:  w = '{op: OP_FACC,  cond: C_NEVER,     target: A_WAIT};
      A_DRAIN: w = '{op: OP_DRAIN, cond: C_CAN_DRAIN, target: A_DRAIN};
      A_FCAP:  w = '{op: OP_FCAP,  cond: C_ALWAYS,    target: A_EMIT};
      A_LADD:  w = '{op: OP_LADD,  cond: C_NEVER,     target: A_WAIT};
      A_LTAKE: w = '{op: OP_LTAKE, cond: C_NEVER,     target: A_WAIT};
      A_LSIM:  w = '{op: OP_LSIM,  cond: C_NEVER,     target: A_WAIT};
      A_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: A_EMIT};
      A_DONE:  w = '{op: OP_NOP,   cond: C_ALWAYS,    target: A_WAIT};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: A_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/fixed_timestep_step_scheduler.sv
// ----------------------------------------------------------------------------
// Fixed-timestep step scheduler
// Turns one frame transaction into the frame's camera and simulated time
// deltas and the number of fixed physics steps to run.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) takes one frame
//   transaction, the output channel (out_valid_o / out_stall_i / out_data_o)
//   returns exactly one result per frame. The configuration channel
//   (cfg_valid_i / cfg_ready_o) writes fixed_dt (index 0) and max_steps
//   (index 1); it is always ready and should be used only while idle.
//   A microcoded sequencer runs a short program per frame, one control word
//   per cycle, on a single shared datapath, so one frame is in flight at a
//   time. A blocked scene frame goes from its load and check steps straight
//   to emit; a lock-step frame runs the tick add, tick take and lock sim
//   steps; a free-running frame multiplies and takes its sim time, and if
//   it steps, accumulates, drains while it can (subtracting fixed_dt once
//   per cycle) and applies the cap. The result is registered in the emit
//   step, and the done step follows it before the input side is ready again.
//   The result sits in an output register, so a stalled receiver does not
//   hold the input side: the next frame is accepted and computed, and the
//   sequencer waits in its emit step only if the previous result is still
//   unread. Reset clears both accumulators, loads the default configuration
//   and empties the output register.
// ----------------------------------------------------------------------------
module fixed_timestep_step_scheduler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ftss_pkg::ftss_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ftss_pkg::ftss_out_t       out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ftss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ftss_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ftss_pkg::*;

  // Control state.
  logic [PC_W-1:0]           pc_q, pc_d;
  logic                      out_valid_q, out_valid_d;

  // Configuration and persistent state.
  logic [FDT_W-1:0]          fixed_dt_q, fixed_dt_d;
  logic [STEPS_W-1:0]        max_steps_q, max_steps_d;
  logic [TICK_ACC_W-1:0]     tick_accum_q, tick_accum_d;
  logic signed [TIME_ACC_W-1:0] time_accum_q, time_accum_d;

  // Per-frame working registers.
  ftss_in_t                  in_q, in_d;
  logic                      upd_q, upd_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [SIM_W-1:0]   sim_q, sim_d;
  logic [STEPS_W-1:0]        steps_q, steps_d;
  logic [TICK_W-1:0]         ticks_q, ticks_d;
  ftss_out_t                 out_q, out_d;

  // Datapath helpers.
  ftss_uword_t               uw;
  logic                      in_accept;
  logic                      out_busy;
  logic                      may_go;
  logic                      cond_true;
  logic                      can_drain;
  logic [STEPS_W-1:0]        cap;
  logic signed [PROD_W:0]    prod_full;
  logic signed [TIME_ACC_W:0] time_sum;
  logic signed [TIME_ACC_W-1:0] fdt_ext;
  logic [TICK_ACC_W:0]       tick_sum;
  logic [TICK_ACC_W-FRAC_W-1:0] tick_int;
  logic [TICK_W-1:0]         ticks_now;
  logic [FDT_W+TICK_W-1:0]   lock_prod;

  assign uw          = ftss_ucode(pc_q);
  assign in_stall_o  = (pc_q != A_WAIT);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_busy    = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Stepping is allowed and there is something to step.
  assign may_go = (!in_q.fly_mode || in_q.nudge_mode || in_q.step_request)
                  && in_q.models_present;

  // Free-mode drain limit.
  assign cap = (max_steps_q > STEPS_W'(STEP_CAP)) ? STEPS_W'(STEP_CAP) : max_steps_q;

  // Scaled frame time; the product of an unsigned 32-bit and a signed
  // 24-bit value always fits 56 signed bits.
  assign prod_full = $signed({1'b0, in_q.frame_seconds}) * $signed(in_q.speed_scale);

  // Saturating accumulate of the scaled frame time.
  assign time_sum = {time_accum_q[TIME_ACC_W-1], time_accum_q}
                  + {{(TIME_ACC_W-SIM_W+1){sim_q[SIM_W-1]}}, sim_q};

  assign fdt_ext   = $signed({{(TIME_ACC_W-FDT_W){1'b0}}, fixed_dt_q});
  assign can_drain = (time_accum_q >= fdt_ext) && (steps_q < cap);

  // Lock-step tick accumulate and take.
  assign tick_sum  = {1'b0, tick_accum_q}
                   + {{(TICK_ACC_W-SCALE_W+2){1'b0}}, in_q.speed_scale[SCALE_W-2:0]};
  assign tick_int  = tick_accum_q[TICK_ACC_W-1:FRAC_W];
  assign ticks_now = (tick_int > (TICK_ACC_W-FRAC_W)'(MAX_LOCK_TICKS))
                   ? TICK_W'(MAX_LOCK_TICKS) : tick_int[TICK_W-1:0];
  assign lock_prod = fixed_dt_q * ticks_q;

  // Jump condition of the current control word.
  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_ITEM:   cond_true = !in_valid_i;
      C_BLOCKED:   cond_true = !upd_q;
      C_LOCK:      cond_true = in_q.lock_step;
      C_NO_STEP:   cond_true = !may_go;
      C_CAN_DRAIN: cond_true = can_drain;
      C_OUT_BUSY:  cond_true = out_busy;
      default:     cond_true = 1'b0;
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    pc_d         = cond_true ? uw.target : pc_q + PC_W'(1);
    out_valid_d  = out_valid_q && out_stall_i;
    fixed_dt_d   = fixed_dt_q;
    max_steps_d  = max_steps_q;
    tick_accum_d = tick_accum_q;
    time_accum_d = time_accum_q;
    in_d         = in_q;
    upd_d        = upd_q;
    prod_d       = prod_q;
    sim_d        = sim_q;
    steps_d      = steps_q;
    ticks_d      = ticks_q;
    out_d        = out_q;

    // Configuration writes; unknown indexes are ignored.
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FIXED_DT) begin
        fixed_dt_d = cfg_data_i[FDT_W-1:0];
      end else if (cfg_index_i == CFG_MAX_STEPS) begin
        max_steps_d = cfg_data_i[STEPS_W-1:0];
      end
    end

    unique case (uw.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_accept) begin
          in_d    = in_data_i;
          upd_d   = !(in_data_i.scene_mode && !in_data_i.scene_physics_on);
          sim_d   = '0;
          steps_d = '0;
        end
      end
      OP_MUL: begin
        prod_d = prod_full[PROD_W-1:0];
      end
      OP_FSIM: begin
        // Arithmetic shift right rounds toward minus infinity.
        sim_d = prod_q[FRAC_W +: SIM_W];
      end
      OP_FACC: begin
        if (time_sum[TIME_ACC_W] != time_sum[TIME_ACC_W-1]) begin
          time_accum_d = time_sum[TIME_ACC_W]
                       ? {1'b1, {(TIME_ACC_W-1){1'b0}}}
                       : {1'b0, {(TIME_ACC_W-1){1'b1}}};
        end else begin
          time_accum_d = time_sum[TIME_ACC_W-1:0];
        end
      end
      OP_DRAIN: begin
        if (can_drain) begin
          time_accum_d = time_accum_q - fdt_ext;
          steps_d      = steps_q + STEPS_W'(1);
        end
      end
      OP_FCAP: begin
        if (steps_q == cap) begin
          time_accum_d = '0;
        end
      end
      OP_LADD: begin
        // Only a positive time scale feeds the tick accumulator.
        if (!in_q.speed_scale[SCALE_W-1] && (in_q.speed_scale != '0)) begin
          tick_accum_d = tick_sum[TICK_ACC_W] ? {TICK_ACC_W{1'b1}}
                                              : tick_sum[TICK_ACC_W-1:0];
        end
      end
      OP_LTAKE: begin
        ticks_d      = ticks_now;
        tick_accum_d = tick_accum_q
                     - {{(TICK_ACC_W-FRAC_W-TICK_W){1'b0}}, ticks_now, {FRAC_W{1'b0}}};
        steps_d      = may_go ? STEPS_W'(ticks_now) : '0;
      end
      OP_LSIM: begin
        sim_d = $signed({{(SIM_W-FDT_W-TICK_W){1'b0}}, lock_prod});
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_d        = 1'b1;
          out_d.update_logic = upd_q;
          out_d.camera_dt    = upd_q ? in_q.frame_seconds : '0;
          out_d.sim_dt       = sim_q;
          out_d.steps_run    = steps_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control, configuration and accumulator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= A_WAIT;
      out_valid_q  <= 1'b0;
      fixed_dt_q   <= FIXED_DT_RESET;
      max_steps_q  <= MAX_STEPS_RESET;
      tick_accum_q <= '0;
      time_accum_q <= '0;
    end else begin
      pc_q         <= pc_d;
      out_valid_q  <= out_valid_d;
      fixed_dt_q   <= fixed_dt_d;
      max_steps_q  <= max_steps_d;
      tick_accum_q <= tick_accum_d;
      time_accum_q <= time_accum_d;
    end
  end

  // Per-frame payload registers.
  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    upd_q   <= upd_d;
    prod_q  <= prod_d;
    sim_q   <= sim_d;
    steps_q <= steps_d;
    ticks_q <= ticks_d;
    out_q   <= out_d;
  end

endmodule

// File: test/fixed_timestep_step_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Fixed-timestep step scheduler testbench
// Drives frame transactions into the scheduler and checks every result
// against a typed-in result or a cycle-free predictor of the lock-step tick
// and free-running time accumulators. A directed stimulus table comes
// first, then random frames under several fixed_dt / max_steps settings,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module fixed_timestep_step_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftss_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned DIRECTED_ROWS = 22;
  localparam int unsigned BURST_LEN     = 264;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned SETTLE_CYCLES = 80;

  // Register index that no register answers to.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  // Mode flag masks, in the order of the input struct's flag fields.
  localparam logic [6:0] F_SCENE  = 7'b100_0000;
  localparam logic [6:0] F_PHYS   = 7'b010_0000;
  localparam logic [6:0] F_FLY    = 7'b001_0000;
  localparam logic [6:0] F_NUDGE  = 7'b000_1000;
  localparam logic [6:0] F_REQ    = 7'b000_0100;
  localparam logic [6:0] F_LOCK   = 7'b000_0010;
  localparam logic [6:0] F_MODELS = 7'b000_0001;

  // Saturation bounds of the simulated time and of the time accumulator.
  localparam longint SIM_HI  = 64'sd549755813887;
  localparam longint SIM_LO  = -64'sd549755813888;
  localparam longint TACC_HI = 64'sd140737488355327;
  localparam longint TACC_LO = -64'sd140737488355328;

  typedef struct {
    ftss_in_t  item;
    bit        typed;
    ftss_out_t result;
  } frame_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  ftss_in_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  ftss_out_t              out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  // Predictor state and its copy of the configuration.
  logic [TICK_ACC_W-1:0]  tick_acc = '0;
  longint                 time_acc = 0;
  logic [FDT_W-1:0]       fdt_q    = FIXED_DT_RESET;
  logic [STEPS_W-1:0]     steps_q  = MAX_STEPS_RESET;

  ftss_out_t              step_expect [$];
  frame_row_t             frame_rows [DIRECTED_ROWS];

  int unsigned            cycles = 0;
  int unsigned            n_sent = 0;
  int unsigned            n_checked = 0;
  int unsigned            n_mismatch = 0;
  int unsigned            n_lock = 0;
  int unsigned            n_blocked = 0;
  int unsigned            n_capped = 0;
  int unsigned            n_floor = 0;
  longint                 total_steps = 0;
  bit                     tx_quiet = 1'b0;
  bit                     rx_quiet = 1'b0;
  int unsigned            rx_hold = 0;

  fixed_timestep_step_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, step_expect.size());
      $display("fixed_timestep_step_scheduler test failed");
      $finish;
    end
  end

  function automatic ftss_in_t mk_frame(input logic [FRAME_W-1:0] frame,
                                        input logic [SCALE_W-1:0] scale,
                                        input logic [6:0] flags);
    ftss_in_t f;
    f.frame_seconds = frame;
    f.speed_scale   = scale;
    {f.scene_mode, f.scene_physics_on, f.fly_mode, f.nudge_mode,
     f.step_request, f.lock_step, f.models_present} = flags;
    return f;
  endfunction

  function automatic ftss_out_t mk_result(input logic [FRAME_W-1:0] frame,
                                          input logic [SIM_W-1:0] sim,
                                          input logic [STEPS_W-1:0] steps);
    ftss_out_t r;
    r.update_logic = 1'b1;
    r.camera_dt    = frame;
    r.sim_dt       = sim;
    r.steps_run    = steps;
    return r;
  endfunction

  // Computes the result of one frame and advances the accumulators.
  function automatic ftss_out_t predict_frame(input ftss_in_t f);
    ftss_out_t         r;
    logic              may_step;
    logic [TICK_ACC_W:0] tsum;
    longint            prod;
    longint            sim;
    longint            ta;
    int unsigned       ticks;
    int unsigned       nsteps;
    int unsigned       cap;
    r = '0;
    nsteps = 0;
    may_step = !f.fly_mode || f.nudge_mode || f.step_request;
    if (f.scene_mode && !f.scene_physics_on) begin
      n_blocked++;
      return r;
    end
    if (f.lock_step) begin
      // Tick accumulator: add the positive scale, take whole ticks up to the cap.
      n_lock++;
      if ($signed(f.speed_scale) > 0) begin
        tsum = {1'b0, tick_acc} + {17'b0, f.speed_scale};
        tick_acc = tsum[TICK_ACC_W] ? '1 : tsum[TICK_ACC_W-1:0];
      end
      ticks = tick_acc[TICK_ACC_W-1:FRAC_W];
      if (ticks > MAX_LOCK_TICKS) ticks = MAX_LOCK_TICKS;
      tick_acc = tick_acc - (TICK_ACC_W'(ticks) << FRAC_W);
      sim = longint'(fdt_q) * longint'(ticks);
      if (may_step && f.models_present) nsteps = ticks;
    end else begin
      // Scaled frame time, floored to 16 fraction bits.
      prod = longint'(f.frame_seconds) * longint'($signed(f.speed_scale));
      sim = prod >>> FRAC_W;
      if (sim > SIM_HI) sim = SIM_HI;
      if (sim < SIM_LO) sim = SIM_LO;
      if (may_step && f.models_present) begin
        ta = time_acc + sim;
        if (ta > TACC_HI) ta = TACC_HI;
        if (ta < TACC_LO) begin
          ta = TACC_LO;
          n_floor++;
        end
        cap = (steps_q > STEP_CAP) ? STEP_CAP : steps_q;
        while (ta >= longint'(fdt_q) && nsteps < cap) begin
          ta = ta - longint'(fdt_q);
          nsteps++;
        end
        if (nsteps == cap) begin
          ta = 0;
          n_capped++;
        end
        time_acc = ta;
      end
    end
    total_steps += nsteps;
    r = mk_result(f.frame_seconds, sim[SIM_W-1:0], nsteps[STEPS_W-1:0]);
    return r;
  endfunction

  // Random frame: mostly plausible frame times and scales, some raw noise.
  function automatic ftss_in_t draw_frame();
    ftss_in_t    f;
    int unsigned pick;
    logic [6:0]  flags;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      f = mk_frame($urandom, SCALE_W'($urandom), 7'($urandom));
    end else begin
      flags = '0;
      if ($urandom_range(0, 4) == 0) flags |= F_SCENE;
      if ($urandom_range(0, 3) != 0) flags |= F_PHYS;
      if ($urandom_range(0, 3) == 0) flags |= F_FLY;
      if ($urandom_range(0, 2) == 0) flags |= F_NUDGE;
      if ($urandom_range(0, 2) == 0) flags |= F_REQ;
      if ($urandom_range(0, 2) == 0) flags |= F_LOCK;
      if ($urandom_range(0, 7) != 0) flags |= F_MODELS;
      f = mk_frame('0, '0, flags);
      pick = $urandom_range(0, 9);
      if (pick < 7) f.frame_seconds = $urandom_range(0, 8192);
      else if (pick < 9) f.frame_seconds = $urandom_range(0, 1 << 20);
      else f.frame_seconds = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 6) f.speed_scale = SCALE_W'($urandom_range(0, 'h30000));
      else if (pick < 8) f.speed_scale = -SCALE_W'($urandom_range(0, 'h20000));
      else if (pick < 9) f.speed_scale = SCALE_W'($urandom_range(0, 'h7FFFFF));
      else f.speed_scale = SCALE_W'($urandom);
    end
    return f;
  endfunction

  // Compares one result with the oldest pending expectation.
  task automatic check_result(input ftss_out_t got);
    ftss_out_t want;
    if (step_expect.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= REPORT_MAX)
        $display("ERROR: result with no frame pending: %p", got);
    end else begin
      want = step_expect.pop_front();
      n_checked++;
      if (got.update_logic !== want.update_logic || got.camera_dt !== want.camera_dt ||
          got.sim_dt !== want.sim_dt || got.steps_run !== want.steps_run) begin
        n_mismatch++;
        if (n_mismatch <= REPORT_MAX) begin
          $display("ERROR: result %0d expected update %b camera_dt %h sim_dt %h steps %0d",
                   n_checked, want.update_logic, want.camera_dt, want.sim_dt,
                   want.steps_run);
          $display("       actual   update %b camera_dt %h sim_dt %h steps %0d",
                   got.update_logic, got.camera_dt, got.sim_dt, got.steps_run);
        end
      end
    end
  endtask

  // Result side: accept, check, then stall for a random number of cycles.
  always @(posedge clk_i) begin : result_side
    int unsigned hold;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
        hold = rx_quiet ? 0 : $urandom_range(0, 9);
        rx_hold <= hold;
        out_stall_i <= (hold != 0);
      end else if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
        out_stall_i <= (rx_hold > 1);
      end
    end
  end

  // Sends one frame transaction after a random gap and records its result.
  task automatic send_frame(input ftss_in_t f, input bit typed, input ftss_out_t want);
    int unsigned gap;
    ftss_out_t   pred;
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= f;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_frame(f);
    step_expect.push_back(typed ? want : pred);
    n_sent++;
  endtask

  // Holds the input side until every pending result has been returned.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (step_expect.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FIXED_DT) fdt_q = data[FDT_W-1:0];
    else if (idx == CFG_MAX_STEPS) steps_q = data[STEPS_W-1:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) == 0) wait_drained();
      send_frame(draw_frame(), 1'b0, '0);
    end
  endtask

  // Drives the time accumulator to its negative limit and back again.
  task automatic run_sink_and_recover();
    for (int unsigned k = 0; k < BURST_LEN; k++)
      send_frame(mk_frame(~FRAME_W'($urandom_range(0, 255)), 24'h800000,
                          F_NUDGE | F_MODELS | ($urandom_range(0, 1) ? F_FLY : 7'b0)),
                 1'b0, '0);
    for (int unsigned k = 0; k < BURST_LEN; k++)
      send_frame(mk_frame(~FRAME_W'($urandom_range(0, 255)), 24'h7FFFFF,
                          F_MODELS | ($urandom_range(0, 1) ? F_REQ : 7'b0)),
                 1'b0, '0);
  endtask

  initial begin
    logic [FDT_W-1:0]      phase_fdt [8];
    logic [CFG_DATA_W-1:0] phase_ms  [8];

    // Directed table; results are typed in only where they are obvious.
    frame_rows[0]  = '{mk_frame('1, 24'h7FFFFF,
                                F_SCENE | F_FLY | F_NUDGE | F_REQ | F_LOCK | F_MODELS),
                       1'b1, '0};
    frame_rows[1]  = '{mk_frame(32'h0001_0000, 24'h800000, F_SCENE), 1'b1, '0};
    frame_rows[2]  = '{mk_frame(32'h0001_0000, 24'h000000, F_LOCK | F_MODELS), 1'b1,
                       mk_result(32'h0001_0000, '0, '0)};
    frame_rows[3]  = '{mk_frame(32'h0000_0444, 24'h800000, F_LOCK | F_MODELS), 1'b1,
                       mk_result(32'h0000_0444, '0, '0)};
    frame_rows[4]  = '{mk_frame(32'h0000_0222, 24'h010000, F_LOCK | F_MODELS), 1'b1,
                       mk_result(32'h0000_0222, 40'd546, 7'd1)};
    frame_rows[5]  = '{mk_frame('0, 24'h7FFFFF, F_MODELS), 1'b1, mk_result('0, '0, '0)};
    frame_rows[6]  = '{mk_frame(32'd546, 24'h010000, F_MODELS), 1'b1,
                       mk_result(32'd546, 40'd546, 7'd1)};
    frame_rows[7]  = '{mk_frame(32'd1000, 24'h010000, F_FLY | F_MODELS), 1'b1,
                       mk_result(32'd1000, 40'd1000, '0)};
    frame_rows[8]  = '{mk_frame(32'd1, 24'hFFFFFF, '0), 1'b1,
                       mk_result(32'd1, 40'hFF_FFFF_FFFF, '0)};
    frame_rows[9]  = '{mk_frame(32'd3, 24'h008000, '0), 1'b1, mk_result(32'd3, 40'd1, '0)};
    frame_rows[10] = '{mk_frame(32'h1111, 24'h7FFFFF, F_LOCK | F_MODELS), 1'b0, '0};
    frame_rows[11] = '{mk_frame(32'h1111, 24'h000000, F_LOCK | F_FLY | F_MODELS), 1'b0, '0};
    frame_rows[12] = '{mk_frame(32'h2222, 24'h020000, F_LOCK), 1'b0, '0};
    frame_rows[13] = '{mk_frame(32'h3333, 24'h018000,
                                F_LOCK | F_FLY | F_NUDGE | F_MODELS), 1'b0, '0};
    frame_rows[14] = '{mk_frame(32'd2000, 24'h010000, F_FLY | F_NUDGE | F_MODELS), 1'b0, '0};
    frame_rows[15] = '{mk_frame(32'd1500, 24'h020000, F_FLY | F_REQ | F_MODELS), 1'b0, '0};
    frame_rows[16] = '{mk_frame(32'd5000, 24'h010000, '0), 1'b0, '0};
    frame_rows[17] = '{mk_frame('1, 24'h7FFFFF, F_MODELS), 1'b0, '0};
    frame_rows[18] = '{mk_frame('1, 24'h800000, F_MODELS), 1'b0, '0};
    frame_rows[19] = '{mk_frame('1, 24'h7FFFFF, F_MODELS), 1'b0, '0};
    frame_rows[20] = '{mk_frame(32'd4000, 24'h010000, F_SCENE | F_PHYS | F_MODELS), 1'b0, '0};
    frame_rows[21] = '{mk_frame(32'd4000, 24'h030000,
                                F_SCENE | F_PHYS | F_LOCK | F_MODELS), 1'b0, '0};

    // Register settings per phase: extremes, zero cases and random values.
    phase_fdt = '{16'd1, 16'd65535, 16'd0, 16'd546, FDT_W'($urandom), 16'd1092, 16'd2184,
                  FDT_W'($urandom)};
    phase_ms  = '{16'd64, 16'd1, 16'd8, 16'd0, 16'd127, 16'd16, 16'd4,
                  CFG_DATA_W'($urandom)};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < DIRECTED_ROWS; i++)
      send_frame(frame_rows[i].item, frame_rows[i].typed, frame_rows[i].result);
    wait_drained();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    run_random(120);

    for (int unsigned p = 0; p < 8; p++) begin
      wait_drained();
      write_reg(CFG_FIXED_DT, CFG_DATA_W'(phase_fdt[p]));
      write_reg(CFG_MAX_STEPS, phase_ms[p]);
      if (p == 6) run_sink_and_recover();
      run_random(110);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d frames (%0d lock-step, %0d scene-blocked) and checked %0d results.",
             n_sent, n_lock, n_blocked, n_checked);
    $display("Predicted %0d physics steps, %0d capped drains, %0d accumulator floor hits.",
             total_steps, n_capped, n_floor);
    if (n_mismatch == 0) begin
      $display("fixed_timestep_step_scheduler test passed");
    end else begin
      $display("%0d result errors", n_mismatch);
      $display("fixed_timestep_step_scheduler test failed");
    end
    $finish;
  end

endmodule
